### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/scm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

  localparam int KEYWORD_COUNT = 20;

  localparam logic [4:0] CodeMotion  = 5'd20;
  localparam logic [4:0] CodeUnknown = 5'd21;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharEmpty = 8'hFF;
  localparam logic [7:0] CharPad   = 8'h20;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharM     = 8'h4D;

  // First character of a key sits in the top byte.
  localparam logic [31:0] KeywordTable [20] = '{
    "STOP", "WF  ", "WB  ", "WLT ", "WRT ", "WLS ", "WRS ", "WFLS",
    "WFRS", "WBLS", "WBRS", "WAL ", "WAR ", "WFLT", "WFRT", "WBLT",
    "WBRT", "SIT ", "BAL ", "M   "
  };

  typedef logic [31:0] key_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] index;
    logic       motion;
    logic [7:0] page;
  } decode_t;

endpackage

`default_nettype wire

### hdl/serial_command_line_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   rx_byte_i
// result    out        out_valid_o / out_ready_i command_code_o, previous_command_o,
//                                                motion_page_o, previous_page_o
//
// An accepted byte lands in an input register and is processed once the output may advance.
// A carriage return yields one registered result item; other bytes
// yield none. One byte per cycle is sustained while results are taken.
// Reset clears the line state, the command and page registers and all valid flags.
// A waiting result stalls the input register, and the input stalls only behind it.

`include "assert_macros.svh"

module serial_command_line_matcher_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [4:0] command_code_o,
  output logic      [4:0] previous_command_o,
  output logic      [7:0] motion_page_o,
  output logic      [7:0] previous_page_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  logic [4:0] out_cmd_q, out_prev_q;
  logic [7:0] out_page_q, out_lpage_q;

  logic [7:0] key_q [4];
  logic [2:0] cnt_q, cnt_d;
  logic [4:0] cur_q, cur_d, last_q, last_d;
  logic [7:0] page_q, page_d, lpage_q, lpage_d;

  logic             adv, is_cr, work;
  logic [7:0]       upper;
  scm_pkg::key_t    key;
  scm_pkg::decode_t dec;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || adv;
  assign is_cr      = (in_byte_q == scm_pkg::CharCr);
  assign work       = in_vld_q && adv;

  assign upper = ((in_byte_q >= scm_pkg::CharLowA) && (in_byte_q <= scm_pkg::CharLowZ)) ?
                 (in_byte_q - 8'd32) : in_byte_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cnt_q) begin
        key[31 - 8 * i -: 8] = key_q[i];
      end else if (i == 0) begin
        key[31 - 8 * i -: 8] = scm_pkg::CharEmpty;
      end else begin
        key[31 - 8 * i -: 8] = scm_pkg::CharPad;
      end
    end
  end

  scm_decode u_decode (
    .key_i (key),
    .dec_o (dec)
  );

  always_comb begin
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    last_d  = last_q;
    page_d  = page_q;
    lpage_d = lpage_q;
    if (is_cr) begin
      cnt_d = 3'd0;
      if (dec.hit) begin
        last_d = cur_q;
        cur_d  = dec.index;
      end else if (dec.motion) begin
        cur_d   = scm_pkg::CodeMotion;
        lpage_d = page_q;
        page_d  = dec.page;
      end else begin
        cur_d = scm_pkg::CodeUnknown;
      end
    end else if (cnt_q < 3'd4) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= 3'd0;
      cur_q     <= 5'd0;
      last_q    <= 5'd0;
      page_q    <= 8'd0;
      lpage_q   <= 8'd0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q && is_cr;
      end
      if (work) begin
        cnt_q   <= cnt_d;
        cur_q   <= cur_d;
        last_q  <= last_d;
        page_q  <= page_d;
        lpage_q <= lpage_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (work && is_cr) begin
      out_cmd_q   <= cur_d;
      out_prev_q  <= last_d;
      out_page_q  <= page_d;
      out_lpage_q <= lpage_d;
    end
    if (work && !is_cr && (cnt_q < 3'd4)) begin
      key_q[cnt_q[1:0]] <= upper;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign command_code_o     = out_cmd_q;
  assign previous_command_o = out_prev_q;
  assign motion_page_o      = out_page_q;
  assign previous_page_o    = out_lpage_q;

  `ASSERT_NEVER(a_cnt_range, cnt_q > 3'd4, "character count beyond four")
  `ASSERT_CLK(a_cr_gives_result, work && is_cr |=> out_valid_o, "line end without result")
  `ASSERT_CLK(a_code_range, out_valid_o |-> command_code_o <= scm_pkg::CodeUnknown,
              "command code out of range")

endmodule

`default_nettype wire

### hdl/scm_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module scm_decode (
  input  scm_pkg::key_t    key_i,
  output scm_pkg::decode_t dec_o
);

  logic [7:0] c0, c1, c2, c3;
  logic       dig1, dig2, dig3;
  logic [3:0] d1, d2, d3;
  logic [9:0] page_wide;
  logic [7:0] t1, t2, t3;

  assign c0 = key_i[31:24];
  assign c1 = key_i[23:16];
  assign c2 = key_i[15:8];
  assign c3 = key_i[7:0];

  assign dig1 = (c1 >= 8'h30) && (c1 <= 8'h39);
  assign dig2 = (c2 >= 8'h30) && (c2 <= 8'h39);
  assign dig3 = (c3 >= 8'h30) && (c3 <= 8'h39);

  assign t1 = c1 - scm_pkg::DigitBase;
  assign t2 = c2 - scm_pkg::DigitBase;
  assign t3 = c3 - scm_pkg::DigitBase;
  assign d1 = t1[3:0];
  assign d2 = t2[3:0];
  assign d3 = t3[3:0];

  always_comb begin
    if (dig2 && dig3) begin
      page_wide = 10'(d1) * 10'd100 + 10'(d2) * 10'd10 + 10'(d3);
    end else if (dig2) begin
      page_wide = 10'(d1) * 10'd10 + 10'(d2);
    end else if (dig3) begin
      page_wide = 10'(d1) * 10'd10 + 10'(d3);
    end else begin
      page_wide = 10'(d1);
    end
  end

  always_comb begin
    dec_o.hit   = 1'b0;
    dec_o.index = 5'd0;
    for (int i = scm_pkg::KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (key_i == scm_pkg::KeywordTable[i]) begin
        dec_o.hit   = 1'b1;
        dec_o.index = 5'(i);
      end
    end
    dec_o.motion = (c0 == scm_pkg::CharM) && dig1;
    dec_o.page   = page_wide[7:0];
  end

endmodule

`default_nettype wire
